// File: rtl/core/ictf_pkg.sv
// ----------------------------------------------------------------------------
// ictf_pkg
// Types and constants shared by the tilt filter modules.
// ----------------------------------------------------------------------------
package ictf_pkg;

	localparam int TabLen   = 24;
	localparam int TabFrac  = 24;
	localparam int GuardBits = 8;
	localparam int HalfTurn = 180;
	localparam int Prescale = 14;
	// CORDIC datapath width: 16-bit operand, prescale, growth and sign.
	localparam int CordW    = 34;
	localparam int AngW     = 36;

	localparam logic [1:0] REG_BLEND = 2'd0;
	localparam logic [1:0] REG_GAIN  = 2'd1;
	localparam logic [1:0] REG_BIAS  = 2'd2;

	localparam logic [15:0] BLEND_RST = 16'd1311;
	localparam logic [23:0] GAIN_RST  = 24'd1309440;

	typedef struct packed {
		logic signed [CordW-1:0] x;
		logic signed [CordW-1:0] y;
		logic signed [AngW-1:0]  ang;
	} cord_vec_t;

	function automatic logic signed [AngW-1:0] atan_tab(input logic [4:0] i);
		logic signed [AngW-1:0] v;
		case (i)
			5'd0: v = 36'sd754974720;
			5'd1: v = 36'sd445687602;
			5'd2: v = 36'sd235489088;
			5'd3: v = 36'sd119537938;
			5'd4: v = 36'sd60000934;
			5'd5: v = 36'sd30029717;
			5'd6: v = 36'sd15018523;
			5'd7: v = 36'sd7509720;
			5'd8: v = 36'sd3754917;
			5'd9: v = 36'sd1877466;
			5'd10: v = 36'sd938734;
			5'd11: v = 36'sd469367;
			5'd12: v = 36'sd234684;
			5'd13: v = 36'sd117342;
			5'd14: v = 36'sd58671;
			5'd15: v = 36'sd29335;
			5'd16: v = 36'sd14668;
			5'd17: v = 36'sd7334;
			5'd18: v = 36'sd3667;
			5'd19: v = 36'sd1833;
			5'd20: v = 36'sd917;
			5'd21: v = 36'sd458;
			5'd22: v = 36'sd229;
			5'd23: v = 36'sd115;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/core/ictf_cordic_cell.sv
// ----------------------------------------------------------------------------
// ictf_cordic_cell
// One CORDIC vectoring rotation with a fixed shift, registered on its output.
// ----------------------------------------------------------------------------
module ictf_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic               clk,
	input  ictf_pkg::cord_vec_t vin,
	output ictf_pkg::cord_vec_t vout_q
);
	import ictf_pkg::*;

	logic signed [CordW-1:0] dx;
	logic signed [CordW-1:0] dy;
	logic signed [AngW-1:0]  da;

	assign dx = vin.y >>> STEP;
	assign dy = vin.x >>> STEP;
	assign da = atan_tab(5'(STEP));

	always_ff @(posedge clk) begin
		if (!vin.y[CordW-1]) begin
			vout_q.x   <= vin.x + dx;
			vout_q.y   <= vin.y - dy;
			vout_q.ang <= vin.ang + da;
		end else begin
			vout_q.x   <= vin.x - dx;
			vout_q.y   <= vin.y + dy;
			vout_q.ang <= vin.ang - da;
		end
	end

endmodule

// File: rtl/core/ictf_cordic_chain.sv
// ----------------------------------------------------------------------------
// ictf_cordic_chain
// atan2(num, den) as a row of CORDIC cells, result in degrees * 2^24.
// ----------------------------------------------------------------------------
module ictf_cordic_chain #(
	parameter int STEPS = 16
) (
	input  logic                           clk,
	input  logic signed [15:0]             num,
	input  logic signed [15:0]             den,
	output logic signed [ictf_pkg::AngW-1:0] ang
);
	import ictf_pkg::*;

	localparam int N = (STEPS < TabLen) ? STEPS : TabLen;

	cord_vec_t v [0:N];
	cord_vec_t v0;
	logic signed [CordW-1:0] xs;
	logic signed [CordW-1:0] ys;
	logic zero_q [0:N];

	assign xs = CordW'(den) <<< Prescale;
	assign ys = CordW'(num) <<< Prescale;

	// Pre-rotation by half a turn when the vector points into the left half plane.
	always_comb begin
		v0.x = xs;
		v0.y = ys;
		v0.ang = '0;
		if (den[15]) begin
			v0.x = -xs;
			v0.y = -ys;
			v0.ang = num[15] ? -(AngW'(HalfTurn) <<< TabFrac) : (AngW'(HalfTurn) <<< TabFrac);
		end
	end

	assign v[0] = v0;
	always_comb zero_q[0] = (num == '0) && (den == '0);

	for (genvar i = 0; i < N; i++) begin : g_cell
		ictf_cordic_cell #(.STEP(i)) u_cell (.clk(clk), .vin(v[i]), .vout_q(v[i+1]));
		always_ff @(posedge clk) zero_q[i+1] <= zero_q[i];
	end

	assign ang = zero_q[N] ? '0 : v[N].ang;

endmodule

// File: rtl/core/imu_complementary_tilt_filter.sv
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter
// Complementary pitch/roll filter and yaw integrator for six-axis IMU samples.
// ----------------------------------------------------------------------------
// One sample is in flight at a time. From acceptance to a valid result it passes
// through every CORDIC cell of the chain in turn (the two atan2 chains run
// side by side), then through tilt rounding with the gyro products, the gyro
// prediction, the blend products, a settling step, and the summed, saturated
// state update. The output register frees the path as soon as the result is
// taken; the next sample may be accepted in that same cycle.
module imu_complementary_tilt_filter #(
	parameter int CORDIC_STEPS    = 16,
	parameter int ANGLE_FRAC_BITS = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
	input  logic [95:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// pitch_angle, roll_angle, yaw_angle
	output logic [63:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import ictf_pkg::*;

	localparam int N        = (CORDIC_STEPS < TabLen) ? CORDIC_STEPS : TabLen;
	localparam int AngShift = TabFrac - ANGLE_FRAC_BITS - GuardBits;
	localparam int GyroShift = 32 - ANGLE_FRAC_BITS - GuardBits;
	localparam int Lat      = N + 4;
	localparam int CntW     = $clog2(Lat + 1);
	localparam logic signed [47:0] Limit =
		48'(HalfTurn) <<< (ANGLE_FRAC_BITS + GuardBits);

	logic [15:0] blend_q;
	logic [23:0] gain_q;
	logic signed [15:0] bias_q;
	logic busy_q;
	logic [CntW-1:0] cnt_q;
	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
	logic signed [31:0] pitch_q, roll_q;
	logic [39:0] yaw_q;
	logic signed [AngW-1:0] pang, rang;
	logic s_acc;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_q <= BLEND_RST;
			gain_q  <= GAIN_RST;
			bias_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BLEND: blend_q <= cfg_data[15:0];
				REG_GAIN:  gain_q  <= cfg_data;
				REG_BIAS:  bias_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign s_tready = !busy_q && (!m_tvalid || m_tready);
	assign s_acc = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (s_acc) begin
			ax_q <= s_tdata[15:0];
			ay_q <= s_tdata[31:16];
			az_q <= s_tdata[47:32];
			gx_q <= s_tdata[63:48];
			gy_q <= s_tdata[79:64];
			gz_q <= s_tdata[95:80];
		end
	end

	// Input registers hold during the whole pass, so the chains see a steady vector.
	ictf_cordic_chain #(.STEPS(CORDIC_STEPS)) u_pitch (.clk(clk), .num(ay_q), .den(az_q),
		.ang(pang));
	ictf_cordic_chain #(.STEPS(CORDIC_STEPS)) u_roll (.clk(clk), .num(ax_q), .den(az_q),
		.ang(rang));

	// Post-CORDIC stage 1: round tilts and form gyro products.
	logic signed [31:0] ptilt_s1, rtilt_s1;
	logic signed [40:0] pgm_s1, rgm_s1, ygm_s1;
	logic signed [AngW-1:0] pr, rr;
	assign pr = (pang + (AngW'(1) <<< (AngShift - 1))) >>> AngShift;
	assign rr = (rang + (AngW'(1) <<< (AngShift - 1))) >>> AngShift;

	// Stage 2: predictions.
	logic signed [33:0] ppred_s2, rpred_s2;
	logic signed [31:0] ptilt_s2, rtilt_s2;
	// Stage 3: blend products.
	logic signed [51:0] pa_s3, pb_s3, ra_s3, rb_s3;

	logic signed [52:0] psum, rsum;
	logic signed [47:0] pres, rres;
	logic signed [16:0] rmb;
	logic signed [40:0] yinc;
	// The gyro weight reaches a full 65536 when the blend weight is zero.
	logic signed [17:0] wc;

	assign rmb = 17'(gz_q) - 17'(bias_q);
	assign wc = 18'sd65536 - 18'($signed({1'b0, blend_q}));

	always_ff @(posedge clk) begin
		ptilt_s1 <= 32'(pr);
		rtilt_s1 <= -32'(rr);
		pgm_s1 <= 41'(gx_q) * 41'($signed({1'b0, gain_q}));
		rgm_s1 <= 41'(gy_q) * 41'($signed({1'b0, gain_q}));
		ygm_s1 <= 41'(rmb) * 41'($signed({1'b0, gain_q}));
		ppred_s2 <= 34'(pitch_q) + 34'((pgm_s1 + (41'sd1 <<< (GyroShift - 1))) >>> GyroShift);
		rpred_s2 <= 34'(roll_q) + 34'((rgm_s1 + (41'sd1 <<< (GyroShift - 1))) >>> GyroShift);
		ptilt_s2 <= ptilt_s1;
		rtilt_s2 <= rtilt_s1;
		pa_s3 <= 52'($signed({1'b0, blend_q})) * 52'(ptilt_s2);
		pb_s3 <= 52'(wc) * 52'(ppred_s2);
		ra_s3 <= 52'($signed({1'b0, blend_q})) * 52'(rtilt_s2);
		rb_s3 <= 52'(wc) * 52'(rpred_s2);
	end

	assign yinc = (ygm_s1 + (41'sd1 <<< (GyroShift - 1))) >>> GyroShift;
	assign psum = 53'(pa_s3) + 53'(pb_s3) + 53'sd32768;
	assign rsum = 53'(ra_s3) + 53'(rb_s3) + 53'sd32768;
	assign pres = 48'(psum >>> 16);
	assign rres = 48'(rsum >>> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			m_tvalid <= 1'b0;
			pitch_q <= '0;
			roll_q <= '0;
			yaw_q <= '0;
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			if (s_acc) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(Lat - 3)) yaw_q <= yaw_q + 40'(yinc);
				if (cnt_q == CntW'(Lat)) begin
					pitch_q <= (pres > Limit) ? 32'(Limit) :
						(pres < -Limit) ? 32'(-Limit) : 32'(pres);
					roll_q <= (rres > Limit) ? 32'(Limit) :
						(rres < -Limit) ? 32'(-Limit) : 32'(rres);
					busy_q <= 1'b0;
					m_tvalid <= 1'b1;
				end
			end
		end
	end

	assign m_tdata = {yaw_q[39:8], 16'(roll_q >>> GuardBits), 16'(pitch_q >>> GuardBits)};

endmodule

// File: rtl/core/ictf_checker.sv
// ----------------------------------------------------------------------------
// ictf_checker
// Port-level checks for the tilt filter.
// ----------------------------------------------------------------------------
module ictf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);
	// A result that waits is held.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
	// A request just taken must not be followed straight away by another.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("second request taken");
	// A result appears only at the end of a pass, while the input was blocked.
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready)) else $error("spurious result");
endmodule

bind imu_complementary_tilt_filter ictf_checker u_ictf_checker (.*);

// File: tb/imu_complementary_tilt_filter_tb.sv
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter_tb
// Self-checking bench for the complementary tilt filter: directed corner
// samples and weight extremes, then bursts of random samples under several register settings,
// with every result compared against an internal fixed-point predictor.
// ----------------------------------------------------------------------------
module imu_complementary_tilt_filter_tb;
	import ictf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int Steps      = 16;
	localparam int FracBits   = 7;
	localparam int AngShift   = TabFrac - FracBits - GuardBits;
	localparam int GyroShift  = 32 - FracBits - GuardBits;
	localparam longint TiltMax = longint'(HalfTurn) <<< (FracBits + GuardBits);
	localparam int IdleLimit  = 20000;

	typedef struct packed {
		logic signed [15:0] rate_z;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_x;
		logic signed [15:0] accel_z;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_x;
	} imu_sample_t;

	typedef struct packed {
		logic signed [31:0] yaw;
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
	} attitude_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;

	// Predictor state and register copies.
	longint pitch_st, roll_st, yaw_st;
	longint weight_q, gain_q, bias_q;
	attitude_t attitude_q[$];
	int mismatches = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	bit stall_pattern = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	imu_complementary_tilt_filter #(
		.CORDIC_STEPS(Steps),
		.ANGLE_FRAC_BITS(FracBits)
	) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint cordic_tilt(longint num, longint den);
		longint x, y, ang, dx, dy;
		x = den * 16384;
		y = num * 16384;
		ang = 0;
		if (num == 0 && den == 0)
			return 0;
		if (x < 0) begin
			ang = (y >= 0 ? 1 : -1) * (longint'(HalfTurn) <<< TabFrac);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < Steps && i < TabLen; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx;
				y -= dy;
				ang += longint'(atan_tab(i[4:0]));
			end else begin
				x -= dx;
				y += dy;
				ang -= longint'(atan_tab(i[4:0]));
			end
		end
		return round_shift(ang, AngShift);
	endfunction

	function automatic longint blend_axis(longint prev, longint tilt, longint rate);
		longint pred, r;
		pred = prev + round_shift(rate * gain_q, GyroShift);
		r = round_shift(weight_q * tilt + (65536 - weight_q) * pred, 16);
		if (r > TiltMax)
			r = TiltMax;
		if (r < -TiltMax)
			r = -TiltMax;
		return r;
	endfunction

	function automatic attitude_t predict_attitude(imu_sample_t s);
		attitude_t a;
		longint inc;
		pitch_st = blend_axis(pitch_st, cordic_tilt(s.accel_y, s.accel_z), s.rate_x);
		roll_st = blend_axis(roll_st, -cordic_tilt(s.accel_x, s.accel_z), s.rate_y);
		inc = round_shift((longint'(s.rate_z) - bias_q) * gain_q, GyroShift);
		yaw_st = (yaw_st + inc) & ((longint'(1) <<< 40) - 1);
		a.pitch = 16'(floor_shift(pitch_st, GuardBits));
		a.roll = 16'(floor_shift(roll_st, GuardBits));
		a.yaw = 32'(yaw_st >>> GuardBits);
		return a;
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_BLEND: weight_q = longint'(val[15:0]);
			REG_GAIN:  gain_q = longint'(val);
			REG_BIAS:  bias_q = longint'($signed(val[15:0]));
			default: ;
		endcase
	endtask

	// Sends one sample; the caller decides about gaps, so tvalid stays up
	// across back-to-back requests.
	task automatic send_sample(imu_sample_t s);
		s_tvalid <= 1'b1;
		s_tdata <= s;
		do @(posedge clk); while (!s_tready);
		attitude_q.push_back(predict_attitude(s));
	endtask

	task automatic gap(int n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (attitude_q.size() != 0)
			@(posedge clk);
		repeat (Steps + 8) @(posedge clk);
	endtask

	function automatic imu_sample_t random_sample(int mode);
		imu_sample_t s;
		s = imu_sample_t'({$urandom, $urandom, $urandom});
		if (mode == 1) begin
			// Plausible motion: gravity mostly on z, small pitch and roll rates.
			s.accel_x = 16'($signed($urandom_range(0, 8000)) - 4000);
			s.accel_y = 16'($signed($urandom_range(0, 8000)) - 4000);
			s.accel_z = 16'($signed($urandom_range(0, 32000)) - 16000);
			s.rate_x = 16'($signed($urandom_range(0, 2000)) - 1000);
			s.rate_y = 16'($signed($urandom_range(0, 2000)) - 1000);
		end else if (mode == 2) begin
			// Zeros and axis extremes to hit the atan2 corners.
			s.accel_x = ($urandom_range(0, 1)) ? 16'sh0 : s.accel_x;
			s.accel_y = ($urandom_range(0, 1)) ? 16'sh0 : 16'sh8000;
			s.accel_z = ($urandom_range(0, 1)) ? 16'sh0 : 16'sh8000;
		end
		return s;
	endfunction

	task automatic random_run(int n);
		int burst;
		burst = 0;
		for (int i = 0; i < n; i++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 24);
				if ($urandom_range(0, 3) != 0)
					gap($urandom_range(1, 30));
			end
			burst--;
			send_sample(random_sample($urandom_range(0, 4) == 0 ? 2 :
				($urandom_range(0, 1) ? 1 : 0)));
		end
		drain();
	endtask

	task automatic test_corners();
		imu_sample_t s;
		s = '0;
		send_sample(s);
		s.accel_z = 16'sh8000;
		send_sample(s);
		s.accel_y = 16'sh7fff;
		s.accel_x = 16'sh8000;
		send_sample(s);
		s = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000};
		repeat (3) send_sample(s);
		s = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff};
		repeat (3) send_sample(s);
		s = '{16'sh1234, 16'sh0, 16'sh0100, 16'sh0, 16'shff00, 16'sh0};
		send_sample(s);
		s = '{16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'shc000};
		send_sample(s);
		drain();
	endtask

	task automatic test_weight_limits();
		imu_sample_t s;
		write_reg(REG_BLEND, 24'd0);
		write_reg(REG_GAIN, 24'hffffff);
		write_reg(REG_BIAS, 24'h008000);
		s = '{16'sh7fff, 16'sh7fff, 16'sh0, 16'sh8000, 16'sh7fff, 16'sh7fff};
		repeat (4) send_sample(s);
		drain();
		write_reg(REG_BLEND, 24'd65535);
		write_reg(REG_BIAS, 24'h007fff);
		s = '{16'sh0, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000};
		repeat (4) send_sample(s);
		drain();
		// Index 3 is not a register; the write must change nothing.
		write_reg(2'd3, 24'hffffff);
	endtask

	task automatic test_random_settings();
		write_reg(REG_BLEND, 24'd1311);
		write_reg(REG_GAIN, 24'd1309440);
		write_reg(REG_BIAS, 24'd0);
		random_run(400);
		for (int k = 0; k < 4; k++) begin
			write_reg(REG_BLEND, 24'($urandom_range(0, 65535)));
			write_reg(REG_GAIN, 24'($urandom));
			write_reg(REG_BIAS, 24'($urandom));
			random_run(210);
		end
	endtask

	// Receiver stall pattern: long open stretches alternate with random stalls.
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0)
			stall_pattern <= ~stall_pattern;
		m_tready <= stall_pattern ? ($urandom_range(0, 2) != 0) : 1'b1;
	end

	always @(posedge clk) begin
		attitude_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			results_seen++;
			if (attitude_q.size() == 0) begin
				$error("result with no sample outstanding: %h", m_tdata);
				mismatches++;
			end else begin
				want = attitude_q.pop_front();
				if (got.pitch !== want.pitch) begin
					$error("pitch_angle expected %0d got %0d", want.pitch, got.pitch);
					mismatches++;
				end
				if (got.roll !== want.roll) begin
					$error("roll_angle expected %0d got %0d", want.roll, got.roll);
					mismatches++;
				end
				if (got.yaw !== want.yaw) begin
					$error("yaw_angle expected %0d got %0d", want.yaw, got.yaw);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("timeout: no request moved for %0d cycles", IdleLimit);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		pitch_st = 0;
		roll_st = 0;
		yaw_st = 0;
		weight_q = 1311;
		gain_q = 1309440;
		bias_q = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corners();
		test_weight_limits();
		test_random_settings();
		if (attitude_q.size() != 0) begin
			$error("%0d results never arrived", attitude_q.size());
			mismatches++;
		end
		$display("covered %0d results: corner samples, weight extremes, five random settings",
			results_seen);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
